@@ sv/eps_pkg.sv @@
// Shared constants and types for the envelope phase splitter.
`timescale 1ns / 1ps
package eps_pkg;
    localparam int W = 16;
    localparam int SQ_W = 2 * W + 1;
    localparam int ROOT_W = W + 1;
    localparam int NUM_W = W + 16 + ((W >= 15) ? (W - 15) : 0);
    localparam int NUM_SHIFT = (W >= 15) ? (W - 15) : 0;
    localparam int DEN_SHIFT = (W >= 15) ? 0 : (15 - W);
    localparam int DEN_W = ROOT_W + DEN_SHIFT + 1;
    localparam int Q_W = NUM_W + 1;

    typedef enum logic [1:0] {
        REG_RUN_ENABLE = 2'd0,
        REG_SCALED_MODE = 2'd1,
        REG_ENV_GAIN = 2'd2,
        REG_PHASE_GAIN = 2'd3
    } reg_index_t;

    // Control fields that travel with each item down the pipeline.
    typedef struct packed {
        logic run;
        logic scaled;
        logic neg_i;
        logic neg_q;
        logic [15:0] env_gain;
        logic [15:0] ph_gain;
    } ctl_t;
endpackage

@@ sv/envelope_phase_splitter.sv @@
// Top level of the envelope phase splitter pipeline.
// Stages: 2 input stages, 17 root stages, stages A and B, NUM_W (33) division stages and 1 final stage.
// Throughput: one item per clock; the square root and both divisions are unrolled
// over register stages, one result bit per stage, so nothing is shared between items.
// A stall freezes every stage; the last stage holds its item until it is taken.
// Reset (rst_n low) empties the pipeline and sets the registers to run, normalized
// mode and unity gains.
`timescale 1ns / 1ps
module envelope_phase_splitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [eps_pkg::W-1:0] i_sample,
    input  logic signed [eps_pkg::W-1:0] q_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [eps_pkg::W-1:0] envelope_out,
    output logic signed [eps_pkg::W-1:0] i_out,
    output logic signed [eps_pkg::W-1:0] q_out,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int W = eps_pkg::W;
    localparam int ROOT_STAGES = eps_pkg::ROOT_W;
    localparam int RS = ROOT_STAGES;
    localparam int DS = eps_pkg::NUM_W;
    localparam int QW = eps_pkg::Q_W;
    localparam int DW = eps_pkg::DEN_W;

    // Whole pipeline advances together when the output is free.
    logic adv;
    assign adv = ~(out_valid & out_stall);
    assign in_stall = ~adv;

    // Configuration registers.
    logic run_reg, scaled_reg;
    logic [15:0] eg_reg, pg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b1;
            scaled_reg <= 1'b0;
            eg_reg <= 16'd16384;
            pg_reg <= 16'd16384;
        end
        else if (cfg_write)
        begin
            unique case (eps_pkg::reg_index_t'(cfg_index))
                eps_pkg::REG_RUN_ENABLE:  run_reg <= cfg_data[0];
                eps_pkg::REG_SCALED_MODE: scaled_reg <= cfg_data[0];
                eps_pkg::REG_ENV_GAIN:    eg_reg <= cfg_data;
                eps_pkg::REG_PHASE_GAIN:  pg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: magnitudes of both components.
    logic v0_reg;
    eps_pkg::ctl_t c0_reg;
    logic [W-1:0] ri0_reg, rq0_reg;
    logic [W:0] abs_i, abs_q;
    always_comb
    begin
        abs_i = i_sample[W-1] ? ({1'b0, ~i_sample} + 1'b1) : {1'b0, i_sample};
        abs_q = q_sample[W-1] ? ({1'b0, ~q_sample} + 1'b1) : {1'b0, q_sample};
    end
    logic [W:0] ai0_w_reg, aq0_w_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v0_reg <= 1'b0;
        else if (adv) v0_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg <= '{run: run_reg, scaled: scaled_reg, neg_i: i_sample[W-1],
                        neg_q: q_sample[W-1], env_gain: eg_reg, ph_gain: pg_reg};
            ai0_w_reg <= abs_i;
            aq0_w_reg <= abs_q;
            ri0_reg <= i_sample;
            rq0_reg <= q_sample;
        end
    end

    // Square in stage 1.
    logic v1_reg;
    eps_pkg::ctl_t c1_reg;
    logic [W:0] ai1_reg, aq1_reg;
    logic [W-1:0] ri1_reg, rq1_reg;
    logic [eps_pkg::SQ_W-1:0] sq1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (adv) v1_reg <= v0_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= c0_reg;
            ai1_reg <= ai0_w_reg;
            aq1_reg <= aq0_w_reg;
            ri1_reg <= ri0_reg;
            rq1_reg <= rq0_reg;
            sq1_reg <= eps_pkg::SQ_W'(ai0_w_reg) * eps_pkg::SQ_W'(ai0_w_reg)
                     + eps_pkg::SQ_W'(aq0_w_reg) * eps_pkg::SQ_W'(aq0_w_reg);
        end
    end

    // Square root: one result bit per stage, remainder and root carried along.
    logic rv_reg [RS+1];
    eps_pkg::ctl_t rc_reg [RS+1];
    logic [W:0] rai_reg [RS+1], raq_reg [RS+1];
    logic [W-1:0] rri_reg [RS+1], rrq_reg [RS+1];
    logic [eps_pkg::SQ_W:0] rrem_reg [RS+1];
    logic [ROOT_STAGES-1:0] rroot_reg [RS+1];
    assign rv_reg[0] = v1_reg;
    assign rc_reg[0] = c1_reg;
    assign rai_reg[0] = ai1_reg;
    assign raq_reg[0] = aq1_reg;
    assign rri_reg[0] = ri1_reg;
    assign rrq_reg[0] = rq1_reg;
    assign rrem_reg[0] = {1'b0, sq1_reg};
    assign rroot_reg[0] = '0;
    for (genvar k = 0; k < RS; k++)
    begin : g_root
        localparam int B = RS - 1 - k;
        logic [eps_pkg::SQ_W+1:0] trial;
        logic [eps_pkg::SQ_W+1:0] sub;
        always_comb
        begin
            sub = ({{(eps_pkg::SQ_W + 2 - ROOT_STAGES){1'b0}}, rroot_reg[k]} << (B + 1))
                + ((eps_pkg::SQ_W + 2)'(1) << (2 * B));
            trial = {1'b0, rrem_reg[k]} - sub;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) rv_reg[k+1] <= 1'b0;
            else if (adv) rv_reg[k+1] <= rv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rc_reg[k+1] <= rc_reg[k];
                rai_reg[k+1] <= rai_reg[k];
                raq_reg[k+1] <= raq_reg[k];
                rri_reg[k+1] <= rri_reg[k];
                rrq_reg[k+1] <= rrq_reg[k];
                if (!trial[eps_pkg::SQ_W+1])
                begin
                    rrem_reg[k+1] <= trial[eps_pkg::SQ_W:0];
                    rroot_reg[k+1] <= rroot_reg[k] | (ROOT_STAGES'(1) << B);
                end
                else
                begin
                    rrem_reg[k+1] <= rrem_reg[k];
                    rroot_reg[k+1] <= rroot_reg[k];
                end
            end
        end
    end

    // Stage A: round the root and form the products.
    logic va_reg;
    eps_pkg::ctl_t ca_reg;
    logic [W-1:0] rawi_a_reg, rawq_a_reg;
    logic [ROOT_STAGES-1:0] m_a_reg;
    logic [W+16:0] pi_a_reg, pq_a_reg;
    logic [ROOT_STAGES+15:0] env_a_reg;
    logic [ROOT_STAGES-1:0] m_round;
    always_comb
    begin
        m_round = rroot_reg[RS]
                + ROOT_STAGES'(rrem_reg[RS] > {{(eps_pkg::SQ_W + 1 - ROOT_STAGES){1'b0}},
                                               rroot_reg[RS]});
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) va_reg <= 1'b0;
        else if (adv) va_reg <= rv_reg[RS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca_reg <= rc_reg[RS];
            rawi_a_reg <= rri_reg[RS];
            rawq_a_reg <= rrq_reg[RS];
            m_a_reg <= m_round;
            pi_a_reg <= rai_reg[RS] * rc_reg[RS].ph_gain;
            pq_a_reg <= raq_reg[RS] * rc_reg[RS].ph_gain;
            env_a_reg <= m_round * rc_reg[RS].env_gain;
        end
    end

    // Stage B: set up the dividers and finish the envelope and scaled outputs.
    logic vb_reg;
    eps_pkg::ctl_t cb_reg;
    logic [W-1:0] rawi_b_reg, rawq_b_reg;
    logic [W-1:0] env_b_reg;
    logic [W+2:0] si_b_reg, sq_b_reg;
    logic [QW-1:0] ni_b_reg, nq_b_reg;
    logic [DW-1:0] den_b_reg;
    logic zero_b_reg;
    logic [ROOT_STAGES+15:0] env_r;
    logic [DW-1:0] den_w;
    always_comb
    begin
        env_r = (env_a_reg + (ROOT_STAGES + 16)'(8192)) >> 14;
        den_w = DW'(m_a_reg) << eps_pkg::DEN_SHIFT;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vb_reg <= 1'b0;
        else if (adv) vb_reg <= va_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cb_reg <= ca_reg;
            rawi_b_reg <= rawi_a_reg;
            rawq_b_reg <= rawq_a_reg;
            env_b_reg <= (env_r > (ROOT_STAGES + 16)'({W{1'b1}})) ? {W{1'b1}} : env_r[W-1:0];
            si_b_reg <= (W + 3)'((pi_a_reg + (W + 17)'(8192)) >> 14);
            sq_b_reg <= (W + 3)'((pq_a_reg + (W + 17)'(8192)) >> 14);
            ni_b_reg <= QW'(pi_a_reg) << eps_pkg::NUM_SHIFT;
            nq_b_reg <= QW'(pq_a_reg) << eps_pkg::NUM_SHIFT;
            den_b_reg <= den_w;
            zero_b_reg <= (m_a_reg == '0);
        end
    end

    // Division pipeline: (num + den/2) / den, one quotient bit per stage.
    logic dv_reg [DS+1];
    eps_pkg::ctl_t dc_reg [DS+1];
    logic [W-1:0] drawi_reg [DS+1], drawq_reg [DS+1], denv_reg [DS+1];
    logic [W+2:0] dsi_reg [DS+1], dsq_reg [DS+1];
    logic [QW-1:0] dni_reg [DS+1], dnq_reg [DS+1];
    logic [QW-1:0] dri_reg [DS+1], drq_reg [DS+1];
    logic [QW-1:0] dqi_reg [DS+1], dqq_reg [DS+1];
    logic [DW-1:0] dden_reg [DS+1];
    logic dz_reg [DS+1];
    assign dv_reg[0] = vb_reg;
    assign dc_reg[0] = cb_reg;
    assign drawi_reg[0] = rawi_b_reg;
    assign drawq_reg[0] = rawq_b_reg;
    assign denv_reg[0] = env_b_reg;
    assign dsi_reg[0] = si_b_reg;
    assign dsq_reg[0] = sq_b_reg;
    assign dni_reg[0] = ni_b_reg + QW'(den_b_reg >> 1);
    assign dnq_reg[0] = nq_b_reg + QW'(den_b_reg >> 1);
    assign dri_reg[0] = '0;
    assign drq_reg[0] = '0;
    assign dqi_reg[0] = '0;
    assign dqq_reg[0] = '0;
    assign dden_reg[0] = den_b_reg;
    assign dz_reg[0] = zero_b_reg;
    for (genvar k = 0; k < DS; k++)
    begin : g_div
        localparam int B = QW - 1 - k;
        logic [QW-1:0] rem_i, rem_q;
        logic bit_i, bit_q;
        eps_divstage u_di (.rem(dri_reg[k]), .den(dden_reg[k]), .num_bit(dni_reg[k][B]),
                           .rem_out(rem_i), .q_bit(bit_i));
        eps_divstage u_dq (.rem(drq_reg[k]), .den(dden_reg[k]), .num_bit(dnq_reg[k][B]),
                           .rem_out(rem_q), .q_bit(bit_q));
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) dv_reg[k+1] <= 1'b0;
            else if (adv) dv_reg[k+1] <= dv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dc_reg[k+1] <= dc_reg[k];
                drawi_reg[k+1] <= drawi_reg[k];
                drawq_reg[k+1] <= drawq_reg[k];
                denv_reg[k+1] <= denv_reg[k];
                dsi_reg[k+1] <= dsi_reg[k];
                dsq_reg[k+1] <= dsq_reg[k];
                dni_reg[k+1] <= dni_reg[k];
                dnq_reg[k+1] <= dnq_reg[k];
                dden_reg[k+1] <= dden_reg[k];
                dz_reg[k+1] <= dz_reg[k];
                dri_reg[k+1] <= rem_i;
                drq_reg[k+1] <= rem_q;
                dqi_reg[k+1] <= dqi_reg[k] | (QW'(bit_i) << B);
                dqq_reg[k+1] <= dqq_reg[k] | (QW'(bit_q) << B);
            end
        end
    end

    // Final stage: the remaining bottom numerator bit, mode select, sign and saturation.
    function automatic logic [W-1:0] sat_sign(input logic [QW-1:0] mag, input logic neg);
        logic [W-1:0] r;
        if (neg)
        begin
            r = (mag > QW'(1 << (W - 1))) ? {1'b1, {(W - 1){1'b0}}}
                                          : W'(~mag + 1'b1);
        end
        else
        begin
            r = (mag > QW'((1 << (W - 1)) - 1)) ? {1'b0, {(W - 1){1'b1}}} : mag[W-1:0];
        end
        return r;
    endfunction

    // The last quotient bit only needs the compare; its remainder is not used.
    logic [QW-1:0] qi_fin, qq_fin, mi, mq;
    logic bi_last, bq_last;
    logic [QW:0] den_last;
    always_comb
    begin
        den_last = {{(QW + 1 - DW){1'b0}}, dden_reg[DS]};
        bi_last = ({dri_reg[DS], dni_reg[DS][0]} >= den_last);
        bq_last = ({drq_reg[DS], dnq_reg[DS][0]} >= den_last);
        qi_fin = dqi_reg[DS] | QW'(bi_last);
        qq_fin = dqq_reg[DS] | QW'(bq_last);
        if (dc_reg[DS].scaled)
        begin
            mi = QW'(dsi_reg[DS]);
            mq = QW'(dsq_reg[DS]);
        end
        else if (dz_reg[DS])
        begin
            mi = '0;
            mq = '0;
        end
        else
        begin
            mi = qi_fin;
            mq = qq_fin;
        end
    end

    logic ov_reg;
    logic [W-1:0] env_o_reg, io_reg, qo_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (adv) ov_reg <= dv_reg[DS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dc_reg[DS].run)
            begin
                env_o_reg <= denv_reg[DS];
                io_reg <= sat_sign(mi, dc_reg[DS].neg_i);
                qo_reg <= sat_sign(mq, dc_reg[DS].neg_q);
            end
            else
            begin
                env_o_reg <= '0;
                io_reg <= drawi_reg[DS];
                qo_reg <= drawq_reg[DS];
            end
        end
    end
    assign out_valid = ov_reg;
    assign envelope_out = env_o_reg;
    assign i_out = io_reg;
    assign q_out = qo_reg;
endmodule

@@ sv/eps_divstage.sv @@
// One restoring-division bit step, instantiated separately for each phase divider.
`timescale 1ns / 1ps
module eps_divstage (
    input  logic [eps_pkg::Q_W-1:0]   rem,
    input  logic [eps_pkg::DEN_W-1:0] den,
    input  logic                      num_bit,
    output logic [eps_pkg::Q_W-1:0]   rem_out,
    output logic                      q_bit
);
    logic [eps_pkg::Q_W:0] trial;
    always_comb
    begin
        trial = {rem, num_bit} - {{(eps_pkg::Q_W + 1 - eps_pkg::DEN_W){1'b0}}, den};
        q_bit = ~trial[eps_pkg::Q_W];
        rem_out = q_bit ? trial[eps_pkg::Q_W-1:0] : {rem[eps_pkg::Q_W-2:0], num_bit};
    end
endmodule

@@ verif/envelope_phase_splitter_checker.sv @@
// Checker that predicts and compares every result item of the envelope phase splitter.
`timescale 1ns / 1ps
module envelope_phase_splitter_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] i_sample,
    input  logic signed [15:0] q_sample,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [15:0]        envelope_out,
    input  logic signed [15:0] i_out,
    input  logic signed [15:0] q_out,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    typedef struct packed {
        logic [15:0] env;
        logic [15:0] iv;
        logic [15:0] qv;
    } split_t;

    split_t split_q[$];
    logic        run_en;
    logic        scaled;
    logic [15:0] env_gain;
    logic [15:0] ph_gain;

    function automatic longint unsigned isqrt_round(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (s > r) r = r + 1;
        return r;
    endfunction

    function automatic logic [15:0] sat_sign(longint unsigned mag, bit neg);
        if (neg)
        begin
            if (mag > 32768) mag = 32768;
            return 16'(-mag);
        end
        if (mag > 32767) mag = 32767;
        return 16'(mag);
    endfunction

    function automatic logic [15:0] phase_of(longint unsigned ax, bit neg, longint unsigned m);
        longint unsigned q;
        longint unsigned num;
        if (scaled)
            q = (ax * ph_gain + 8192) >> 14;
        else
        begin
            if (m == 0) return 16'd0;
            num = (ax * ph_gain) << eps_pkg::NUM_SHIFT;
            q = (num + ((m << eps_pkg::DEN_SHIFT) >> 1)) / (m << eps_pkg::DEN_SHIFT);
        end
        return sat_sign(q, neg);
    endfunction

    function automatic split_t predict_split(logic signed [15:0] iv, logic signed [15:0] qv);
        split_t r;
        longint unsigned ai;
        longint unsigned aq;
        longint unsigned m;
        longint unsigned e;
        if (!run_en)
        begin
            r.env = 16'd0;
            r.iv = iv;
            r.qv = qv;
            return r;
        end
        ai = (iv < 0) ? longint'(-int'(iv)) : longint'(iv);
        aq = (qv < 0) ? longint'(-int'(qv)) : longint'(qv);
        m = isqrt_round(ai * ai + aq * aq);
        e = (m * env_gain + 8192) >> 14;
        r.env = (e > 65535) ? 16'hFFFF : 16'(e);
        r.iv = phase_of(ai, iv < 0, m);
        r.qv = phase_of(aq, qv < 0, m);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        split_t want;
        if (!rst_n)
        begin
            run_en <= 1'b1;
            scaled <= 1'b0;
            env_gain <= 16'd16384;
            ph_gain <= 16'd16384;
            split_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                split_q.push_back(predict_split(i_sample, q_sample));
            if (out_valid && !out_stall)
            begin
                if (split_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result env=%h i=%h q=%h",
                                 envelope_out, i_out, q_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = split_q.pop_front();
                    if (want.env !== envelope_out || want.iv !== i_out
                        || want.qv !== q_out)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: want env=%h i=%h q=%h got env=%h i=%h q=%h",
                                     want.env, want.iv, want.qv,
                                     envelope_out, i_out, q_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= split_q.size();
            if (cfg_write)
            begin
                case (eps_pkg::reg_index_t'(cfg_index))
                    eps_pkg::REG_RUN_ENABLE:  run_en <= cfg_data[0];
                    eps_pkg::REG_SCALED_MODE: scaled <= cfg_data[0];
                    eps_pkg::REG_ENV_GAIN:    env_gain <= cfg_data;
                    eps_pkg::REG_PHASE_GAIN:  ph_gain <= cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ verif/envelope_phase_splitter_tb.sv @@
// Testbench top: stimulus, configuration phases and the final verdict.
`timescale 1ns / 1ps
module envelope_phase_splitter_tb;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        envelope_out;
    logic signed [15:0] i_out;
    logic signed [15:0] q_out;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 calm;

    // The pipeline is 55 stages deep; allow margin.
    localparam int DRAIN_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 4000;

    envelope_phase_splitter u_dut (.*);

    envelope_phase_splitter_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiving side stalls at random, except during the calm stretch.
    always @(negedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
    end

    // Watchdog: count cycles in which no item moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drive one item and hold it until it is accepted. Valid stays high
    // straight into the next item when there is no idle gap.
    task automatic send_item(logic signed [15:0] iv, logic signed [15:0] qv);
        while (!calm && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        i_sample <= iv;
        q_sample <= qv;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Registers change only once the pipeline is empty.
    task automatic write_reg(eps_pkg::reg_index_t idx, logic [15:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random samples lean toward the extremes now and then so that
    // saturation and tiny magnitudes are reached often.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'($urandom_range(8)) - 16'd4;
            1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] corner [8];
        rst_n = 1'b0;
        in_valid = 1'b0;
        i_sample = '0;
        q_sample = '0;
        cfg_write = 1'b0;
        cfg_index = eps_pkg::REG_RUN_ENABLE;
        cfg_data = '0;
        calm = 1'b0;
        corner = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd3, 16'sh4000, -16'sh4000};
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at reset settings: extremes, zero magnitude and
        // the full-scale corner where the magnitude exceeds the range.
        for (int k = 0; k < 8; k++)
            send_item(corner[k], corner[(k * 3 + 1) % 8]);
        send_item(-16'sh8000, -16'sh8000);
        send_item(16'sh7FFF, 16'sh7FFF);
        send_item(16'sd0, 16'sd0);
        // Scaled mode with the largest gains, then bypass.
        write_reg(eps_pkg::REG_SCALED_MODE, 16'hFFFF);
        write_reg(eps_pkg::REG_PHASE_GAIN, 16'hFFFF);
        write_reg(eps_pkg::REG_ENV_GAIN, 16'hFFFF);
        for (int k = 0; k < 6; k++)
            send_item(corner[k], corner[7 - k]);
        write_reg(eps_pkg::REG_RUN_ENABLE, 16'hFFFE);
        for (int k = 0; k < 5; k++)
            send_item(corner[k], corner[k + 3]);

        // Random phases, each with fresh settings; one phase is calm.
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(eps_pkg::REG_RUN_ENABLE, (ph % 5 == 4) ? 16'd0 : 16'($urandom) | 16'd1);
            write_reg(eps_pkg::REG_SCALED_MODE, 16'(ph % 2));
            write_reg(eps_pkg::REG_ENV_GAIN, pick_gain());
            write_reg(eps_pkg::REG_PHASE_GAIN, (ph == 0) ? 16'd0 : pick_gain());
            calm = (ph == 3);
            for (int n = 0; n < 125; n++)
                send_item(pick_sample(), pick_sample());
            calm = 1'b0;
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
